/* rtl/sha_pkg.sv */
// SHA-256 shared types, constants and functions.
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [255:0] INIT_HASH = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   // Block handed from front to back.
   typedef struct packed {
      logic [511:0] block;
      logic         final_blk;
   } blk_type;

endpackage

/* rtl/sha_front.sv */
// SHA-256 front end: byte packing, padding and block hand-off.
module sha_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  sha_pkg::req_type req_data,
   output logic            blk_valid,
   input  logic            blk_ready,
   output sha_pkg::blk_type blk_data
);
   import sha_pkg::*;

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_PAD  = 2'd1;
   localparam logic [1:0] ST_LEN  = 2'd2;

   logic [1:0]   state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [60:0]  count_ff, count_in;
   logic         bvalid_ff, bvalid_in;
   blk_type      bdata_ff, bdata_in;
   logic [5:0]   pos;
   logic [63:0]  bits;
   logic [511:0] padded;
   logic         out_free;

   assign pos       = count_ff[5:0];
   assign bits      = {count_ff, 3'b000};
   assign out_free  = !bvalid_ff || blk_ready;
   assign req_ready = (state_ff == ST_LOAD) && out_free;
   assign blk_valid = bvalid_ff;
   assign blk_data  = bdata_ff;

   always_comb begin
      // buffer with 0x80 at pos and zeros after
      padded = buf_ff;
      for (int i = 0; i < 64; i++) begin
         if (6'(i) == pos) padded[511 - 8*i -: 8] = 8'h80;
         else if (6'(i) > pos) padded[511 - 8*i -: 8] = 8'h00;
      end
   end

   always_comb begin
      logic [60:0]  cnt;
      logic [511:0] b;
      state_in  = state_ff;
      buf_in    = buf_ff;
      count_in  = count_ff;
      bvalid_in = bvalid_ff && !blk_ready;
      bdata_in  = bdata_ff;
      cnt = count_ff;
      b   = buf_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_ready) begin
               if (req_data.byte_present) begin
                  b[511 - 8*pos -: 8] = req_data.data_byte;
                  cnt = count_ff + 61'd1;
                  if (pos == 6'd63) begin
                     bvalid_in = 1'b1;
                     bdata_in  = '{block: b, final_blk: 1'b0};
                  end
               end
               buf_in   = b;
               count_in = cnt;
               if (req_data.is_last) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (out_free) begin
               if (pos >= 6'd56) begin
                  bvalid_in = 1'b1;
                  bdata_in  = '{block: padded, final_blk: 1'b0};
                  state_in  = ST_LEN;
               end else begin
                  bvalid_in = 1'b1;
                  bdata_in  = '{block: {padded[511:64], bits}, final_blk: 1'b1};
                  count_in  = '0;
                  state_in  = ST_LOAD;
               end
            end
         end
         default: begin
            if (out_free) begin
               bvalid_in = 1'b1;
               bdata_in  = '{block: {448'd0, bits}, final_blk: 1'b1};
               count_in  = '0;
               state_in  = ST_LOAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         count_ff  <= '0;
         bvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bvalid_ff <= bvalid_in;
      end
      buf_ff   <= buf_in;
      bdata_ff <= bdata_in;
   end

endmodule

/* rtl/sha_core.sv */
// SHA-256 back end: compression rounds, chaining value and digest output.
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             blk_valid,
   output logic             blk_ready,
   input  sha_pkg::blk_type blk_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]   state_ff, state_in;
   logic [255:0] hash_ff, hash_in;
   logic [255:0] work_ff, work_in;
   logic [511:0] sched_ff, sched_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         final_ff, final_in;
   logic [2:0]   widx_ff, widx_in;

   logic [31:0] a, b, c, d, e, f, g, h, w, x, y, wn, t1, t2;

   assign blk_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_data  = '{digest_word: hash_ff[255 - 32*widx_ff -: 32],
                        word_index: widx_ff, last_word: (widx_ff == 3'd7)};

   // sched_ff holds the 16-word window, word for this round at the top
   always_comb begin
      {a, b, c, d, e, f, g, h} = work_ff;
      w  = sched_ff[511:480];
      x  = sched_ff[479:448];
      y  = sched_ff[63:32];
      wn = sched_ff[511:480] + ({x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3))
           + sched_ff[223:192]
           + ({y[16:0], y[31:17]} ^ {y[18:0], y[31:19]} ^ (y >> 10));
      t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
           + ((e & f) ^ (~e & g)) + round_k(rnd_ff) + w;
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
           + ((a & b) ^ (a & c) ^ (b & c));
   end

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      rnd_in   = rnd_ff;
      final_in = final_ff;
      widx_in  = widx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (blk_valid) begin
               sched_in = blk_data.block;
               final_in = blk_data.final_blk;
               work_in  = hash_ff;
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            work_in  = {t1 + t2, a, b, c, d + t1, e, f, g};
            sched_in = {sched_ff[479:0], wn};
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_ADD;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++)
               hash_in[255 - 32*i -: 32] = hash_ff[255 - 32*i -: 32] + work_ff[255 - 32*i -: 32];
            widx_in  = '0;
            state_in = final_ff ? ST_EMIT : ST_IDLE;
         end
         default: begin
            if (rsp_ready) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd7) begin
                  hash_in  = INIT_HASH;
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff  <= INIT_HASH;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         widx_ff  <= widx_in;
      end
      work_ff  <= work_in;
      sched_ff <= sched_in;
      rnd_ff   <= rnd_in;
      final_ff <= final_in;
   end

endmodule

/* rtl/sha256_message_digest.sv */
// SHA-256 byte-stream digest, top level.
//   channel | dir | handshake              | payload
//   req     | in  | req_valid / req_ready  | data_byte, byte_present, is_last
//   rsp     | out | rsp_valid / rsp_ready  | digest_word, word_index, last_word
// One byte per cycle into the packer while req_ready is high; a full block is staged
// in a one-entry hand-off register, and the packer takes no further bytes until the
// core accepts it, then loads the next block while compression runs one round per cycle.
// A final request adds one or two pad blocks then eight digest words.
// Synchronous reset restores the initial hash; either side may stall freely.
module sha256_message_digest (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sha_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   logic    blk_valid, blk_ready;
   blk_type blk_data;

   sha_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .blk_valid, .blk_ready, .blk_data
   );

   sha_core u_core (
      .clock, .reset, .blk_valid, .blk_ready, .blk_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule
